/* rtl/rne_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Roman numeral encoder package
// Letter codes, decimal digit bundle and queue defaults shared by the core.
// ---------------------------------------------------------------------------
package rne_pkg;

   localparam int unsigned LETTER_W = 3;
   localparam int unsigned VALUE_W  = 12;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [LETTER_W-1:0] LET_I = 3'd0;
   localparam logic [LETTER_W-1:0] LET_V = 3'd1;
   localparam logic [LETTER_W-1:0] LET_X = 3'd2;
   localparam logic [LETTER_W-1:0] LET_L = 3'd3;
   localparam logic [LETTER_W-1:0] LET_C = 3'd4;
   localparam logic [LETTER_W-1:0] LET_D = 3'd5;
   localparam logic [LETTER_W-1:0] LET_M = 3'd6;

   typedef struct packed {
      logic [2:0] thou;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] unit;
   } digits_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } queue_stat_type;

   typedef struct packed {
      logic busy;
      logic finish;
   } back_stat_type;

endpackage

/* rtl/roman_numeral_encoder_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Roman numeral encoder core
// The first letter of a number passes three digit-split stages, the queue
// and the sequencer before it appears on an idle core.
// Throughput: one letter per cycle while rsp_stall is low; a number has
// up to 15 letters, and a number with no letters gives no letter beat.
// Reset clears all valid flags, queue pointers and the sequencer at once.
// ---------------------------------------------------------------------------
module roman_numeral_encoder_core
   import rne_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [LETTER_W-1:0] rsp_letter,
   output logic                rsp_last
);

   logic           dig_valid;
   digits_type     dig_data;
   digits_type     q_data;
   logic           q_push, q_pop;
   queue_stat_type q_stat;
   back_stat_type  b_stat;

   assign q_push = dig_valid && q_stat.ready;

   rne_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .dig_valid (dig_valid),
      .dig_ready (q_stat.ready),
      .dig_data  (dig_data)
   );

   rne_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (dig_data),
      .pop       (q_pop),
      .pop_data  (q_data),
      .stat      (q_stat)
   );

   rne_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_stat.valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .stat       (b_stat),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_last)
   );

   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> b_stat.busy)
      else $error("sequencer idle while a numeral is unfinished");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      q_stat.valid || q_stat.ready)
      else $error("queue reports full and empty at once");

   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      b_stat.finish |-> b_stat.busy && !(rsp_valid && !rsp_last && rsp_stall))
      else $error("numeral finished with letters still held");

endmodule

/* rtl/rne_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Roman numeral encoder front end
// Three-stage pipeline that splits the binary value into decimal digits.
// ---------------------------------------------------------------------------
module rne_front
   import rne_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   output logic               dig_valid,
   input  logic               dig_ready,
   output digits_type         dig_data
);

   function automatic logic [VALUE_W-1:0] thou_base(input logic [2:0] t);
      case (t)
         3'd0:    thou_base = 12'd0;
         3'd1:    thou_base = 12'd1000;
         3'd2:    thou_base = 12'd2000;
         3'd3:    thou_base = 12'd3000;
         3'd4:    thou_base = 12'd4000;
         default: thou_base = 12'd0;
      endcase
   endfunction

   function automatic logic [9:0] hund_base(input logic [3:0] h);
      case (h)
         4'd0:    hund_base = 10'd0;
         4'd1:    hund_base = 10'd100;
         4'd2:    hund_base = 10'd200;
         4'd3:    hund_base = 10'd300;
         4'd4:    hund_base = 10'd400;
         4'd5:    hund_base = 10'd500;
         4'd6:    hund_base = 10'd600;
         4'd7:    hund_base = 10'd700;
         4'd8:    hund_base = 10'd800;
         4'd9:    hund_base = 10'd900;
         default: hund_base = 10'd0;
      endcase
   endfunction

   function automatic logic [6:0] tens_base(input logic [3:0] t);
      case (t)
         4'd0:    tens_base = 7'd0;
         4'd1:    tens_base = 7'd10;
         4'd2:    tens_base = 7'd20;
         4'd3:    tens_base = 7'd30;
         4'd4:    tens_base = 7'd40;
         4'd5:    tens_base = 7'd50;
         4'd6:    tens_base = 7'd60;
         4'd7:    tens_base = 7'd70;
         4'd8:    tens_base = 7'd80;
         4'd9:    tens_base = 7'd90;
         default: tens_base = 7'd0;
      endcase
   endfunction

   logic       s1_valid_ff, s1_valid_in;
   logic [2:0] s1_thou_ff, s1_thou_in;
   logic [9:0] s1_rest_ff, s1_rest_in;
   logic       s2_valid_ff, s2_valid_in;
   logic [2:0] s2_thou_ff;
   logic [3:0] s2_hund_ff, s2_hund_in;
   logic [6:0] s2_rest_ff, s2_rest_in;
   logic       s3_valid_ff, s3_valid_in;
   digits_type s3_data_ff, s3_data_in;
   logic       s1_ready, s2_ready, s3_ready;
   logic [3:0] tens_q;

   assign s3_ready  = !s3_valid_ff || dig_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign dig_valid = s3_valid_ff;
   assign dig_data  = s3_data_ff;

   always_comb begin
      if (req_value >= 12'd4000) begin
         s1_thou_in = 3'd4;
      end else if (req_value >= 12'd3000) begin
         s1_thou_in = 3'd3;
      end else if (req_value >= 12'd2000) begin
         s1_thou_in = 3'd2;
      end else if (req_value >= 12'd1000) begin
         s1_thou_in = 3'd1;
      end else begin
         s1_thou_in = 3'd0;
      end
      s1_rest_in = 10'(req_value - thou_base(s1_thou_in));
   end

   always_comb begin
      s2_hund_in = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         s2_hund_in = s2_hund_in + 4'(s1_rest_ff >= 10'(k * 100));
      end
      s2_rest_in = 7'(s1_rest_ff - hund_base(s2_hund_in));
   end

   always_comb begin
      tens_q = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         tens_q = tens_q + 4'(s2_rest_ff >= 7'(k * 10));
      end
      s3_data_in.thou = s2_thou_ff;
      s3_data_in.hund = s2_hund_ff;
      s3_data_in.tens = tens_q;
      s3_data_in.unit = 4'(s2_rest_ff - tens_base(tens_q));
   end

   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_thou_ff <= s1_thou_in;
         s1_rest_ff <= s1_rest_in;
      end
      if (s2_ready) begin
         s2_thou_ff <= s1_thou_ff;
         s2_hund_ff <= s2_hund_in;
         s2_rest_ff <= s2_rest_in;
      end
      if (s3_ready) begin
         s3_data_ff <= s3_data_in;
      end
   end

endmodule

/* rtl/rne_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Roman numeral encoder digit queue
// Small register queue that decouples digit split from letter emission.
// ---------------------------------------------------------------------------
module rne_queue
   import rne_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  digits_type     push_data,
   input  logic           pop,
   output digits_type     pop_data,
   output queue_stat_type stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   digits_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         bump = '0;
      end else begin
         bump = p + PTR_W'(1);
      end
   endfunction

   assign stat.valid = (count_ff != '0);
   assign stat.ready = (count_ff != CNT_W'(DEPTH));
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/rne_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Roman numeral encoder back end
// Letter sequencer that walks the decades and emits one letter per beat.
// ---------------------------------------------------------------------------
module rne_back
   import rne_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  digits_type          q_data,
   output logic                q_pop,
   output back_stat_type       stat,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [LETTER_W-1:0] rsp_letter,
   output logic                rsp_last
);

   function automatic logic [2:0] digit_len(input logic [3:0] g);
      case (g) inside
         [4'd0:4'd3]: digit_len = g[2:0];
         4'd4, 4'd9:  digit_len = 3'd2;
         [4'd5:4'd8]: digit_len = 3'(g - 4'd4);
         default:     digit_len = 3'd0;
      endcase
   endfunction

   function automatic logic [LETTER_W-1:0] pick(
      input logic [3:0]          g,
      input logic [1:0]          p,
      input logic [LETTER_W-1:0] one,
      input logic [LETTER_W-1:0] five,
      input logic [LETTER_W-1:0] ten
   );
      case (g) inside
         4'd9:        pick = (p == 2'd0) ? one : ten;
         4'd4:        pick = (p == 2'd0) ? one : five;
         [4'd5:4'd8]: pick = (p == 2'd0) ? five : one;
         default:     pick = one;
      endcase
   endfunction

   logic                busy_ff, busy_in;
   digits_type          cur_ff, cur_in;
   logic [1:0]          ptr_ff, ptr_in;
   logic [1:0]          pos_ff, pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LETTER_W-1:0] rsp_letter_ff, rsp_letter_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [2:0]          len [4];
   logic [3:0]          has;
   logic [1:0]          sel;
   logic                any, more_after, digit_end, is_last;
   logic                out_free, emit, finish;
   logic [LETTER_W-1:0] letter;

   always_comb begin
      len[0] = cur_ff.thou;
      len[1] = digit_len(cur_ff.hund);
      len[2] = digit_len(cur_ff.tens);
      len[3] = digit_len(cur_ff.unit);
      for (int d = 0; d < 4; d++) begin
         has[d] = busy_ff && (2'(d) >= ptr_ff) && (len[d] != 3'd0);
      end
      sel = 2'd0;
      for (int d = 3; d >= 0; d--) begin
         if (has[d]) begin
            sel = 2'(d);
         end
      end
      any        = |has;
      more_after = 1'b0;
      for (int d = 0; d < 4; d++) begin
         if ((2'(d) > sel) && has[d]) begin
            more_after = 1'b1;
         end
      end
      digit_end = ({1'b0, pos_ff} + 3'd1) == len[sel];
      is_last   = digit_end && !more_after;
      case (sel)
         2'd0:    letter = LET_M;
         2'd1:    letter = pick(cur_ff.hund, pos_ff, LET_C, LET_D, LET_M);
         2'd2:    letter = pick(cur_ff.tens, pos_ff, LET_X, LET_L, LET_C);
         2'd3:    letter = pick(cur_ff.unit, pos_ff, LET_I, LET_V, LET_X);
         default: letter = LET_M;
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = out_free && any;
   assign finish   = busy_ff && (!any || (emit && is_last));
   assign q_pop    = q_valid && (!busy_ff || finish);

   always_comb begin
      busy_in       = busy_ff;
      cur_in        = cur_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_letter_in = rsp_letter_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_letter_in = letter;
         rsp_last_in   = is_last;
         if (digit_end) begin
            ptr_in = 2'(sel + 2'd1);
            pos_in = 2'd0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         busy_in = 1'b0;
      end
      if (q_pop) begin
         busy_in = 1'b1;
         cur_in  = q_data;
         ptr_in  = 2'd0;
         pos_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         ptr_ff       <= 2'd0;
         pos_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         ptr_ff       <= ptr_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      rsp_letter_ff <= rsp_letter_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign stat.busy   = busy_ff;
   assign stat.finish = finish;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_letter  = rsp_letter_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

/* tb/tb_roman_numeral_encoder_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Roman numeral encoder core testbench
// Feeds numbers through the request channel and checks every letter beat
// against a behavioral encoder kept in a scoreboard. The run starts with
// directed values: extremes, zero, values past 3999, and the four and nine
// patterns. Random values follow. Requests idle and letters stall at random.
// ---------------------------------------------------------------------------
module tb_roman_numeral_encoder_core;
   import rne_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned RANDOM_ITEMS = 127;
   localparam int unsigned DRAIN_CYCLES = 40;

   class numeral_scoreboard;
      typedef struct packed {
         logic [LETTER_W-1:0] letter;
         logic                last;
      } letter_beat_type;

      letter_beat_type expected_letters[$];
      int unsigned     failures;

      function new();
         failures = 0;
      endfunction

      function void push_letter(logic [LETTER_W-1:0] code);
         letter_beat_type b;
         b.letter = code;
         b.last   = 1'b0;
         expected_letters.insert(expected_letters.size(), b);
      endfunction

      function void push_digit(int unsigned digit, logic [LETTER_W-1:0] one,
                               logic [LETTER_W-1:0] five, logic [LETTER_W-1:0] ten);
         int unsigned d;
         d = digit;
         if (d == 9) begin
            push_letter(one);
            push_letter(ten);
         end else if (d == 4) begin
            push_letter(one);
            push_letter(five);
         end else begin
            if (d >= 5) begin
               push_letter(five);
               d = d - 5;
            end
            repeat (d) push_letter(one);
         end
      endfunction

      function void note_number(logic [VALUE_W-1:0] value);
         int unsigned     v;
         int unsigned     rest;
         int unsigned     before_count;
         letter_beat_type b;
         v            = value;
         rest         = v % 1000;
         before_count = expected_letters.size();
         repeat (v / 1000) push_letter(LET_M);
         push_digit(rest / 100, LET_C, LET_D, LET_M);
         push_digit((rest / 10) % 10, LET_X, LET_L, LET_C);
         push_digit(rest % 10, LET_I, LET_V, LET_X);
         if (expected_letters.size() > before_count) begin
            b      = expected_letters.pop_back();
            b.last = 1'b1;
            expected_letters.insert(expected_letters.size(), b);
         end
      endfunction

      function void check_letter(logic [LETTER_W-1:0] letter, logic last);
         letter_beat_type b;
         if (expected_letters.size() == 0) begin
            $display("%0t: unexpected letter beat: letter %0d last %0d",
                     $time, letter, last);
            failures++;
            return;
         end
         b = expected_letters.pop_front();
         if (letter !== b.letter) begin
            $display("%0t: letter mismatch: expected %0d actual %0d",
                     $time, b.letter, letter);
            failures++;
         end
         if (last !== b.last) begin
            $display("%0t: last mismatch: expected %0d actual %0d",
                     $time, b.last, last);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_letters.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid;
   logic                req_stall;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [LETTER_W-1:0] rsp_letter;
   logic                rsp_last;

   numeral_scoreboard sb;
   int                req_burst = 0;
   int                rsp_burst = 0;
   int unsigned       idle_cycles;

   roman_numeral_encoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(4, 16);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   task automatic send_number(input logic [VALUE_W-1:0] v);
      int gap;
      gap = draw_gap(req_burst);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] random_number();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel == 0)
         return '0;
      else if (sel <= 2)
         return VALUE_W'($urandom_range(4000, 4095));
      else if (sel <= 6)
         return VALUE_W'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100 +
                         $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
      else
         return VALUE_W'($urandom_range(1, 3999));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall)
            sb.note_number(req_value);
         if (rsp_valid && !rsp_stall)
            sb.check_letter(rsp_letter, rsp_last);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : letter_sink
      int gap;
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         gap = draw_gap(rsp_burst);
         repeat (gap) begin
            rsp_stall <= 1'b1;
            @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : number_source
      logic [VALUE_W-1:0] directed_values[$];
      sb        = new();
      req_valid = 1'b0;
      req_value = '0;
      directed_values = '{12'd1, 12'd3999, 12'd3888, 12'd0, 12'd4000, 12'd4095,
                          12'd4, 12'd9, 12'd5, 12'd8, 12'd40, 12'd90, 12'd400,
                          12'd900, 12'd444, 12'd999, 12'd1000, 12'd2048, 12'd1994,
                          12'd2730, 12'd1365, 12'd3949, 12'd4094};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_values[i])
         send_number(directed_values[i]);
      repeat (RANDOM_ITEMS)
         send_number(random_number());
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
